// ===== design/hsv2rgb_pkg.sv =====
package hsv2rgb_pkg;

	localparam int unsigned SECTOR_STEPS = 1530;
	localparam int unsigned SCALE_IN = 254;
	localparam int unsigned SCALE_OUT = 255;
	localparam int unsigned HALF_IN = 127;

	localparam int unsigned SECT_W = 11;
	localparam int unsigned PROD_W = 16;

	typedef enum logic [2:0] {
		RGN_RY,
		RGN_YG,
		RGN_GC,
		RGN_CB,
		RGN_BM,
		RGN_MR
	} region_t;

	typedef struct packed {
		logic [SECT_W-1:0] sector;
		logic [7:0] sat;
		logic [7:0] val;
	} front_t;

	// 0..254 -> 0..255 with rounding: x + (x >= 127), saturating at 255
	function automatic logic [7:0] widen(input logic [7:0] x);
		logic [8:0] sum;
		begin
			sum = {1'b0, x} + ((x >= 8'(HALF_IN)) ? 9'd1 : 9'd0);
			widen = sum[8] ? 8'(SCALE_OUT) : sum[7:0];
		end
	endfunction

	// floor(y / 255) for y < 65280
	function automatic logic [7:0] div255(input logic [PROD_W-1:0] y);
		logic [PROD_W:0] sum;
		begin
			sum = {1'b0, y} + {9'b0, y[PROD_W-1:8]} + 17'd1;
			div255 = sum[PROD_W-1:8];
		end
	endfunction

endpackage

// ===== design/hsv2rgb_front.sv =====
module hsv2rgb_front (
	input  logic [7:0]            boost,
	input  logic [7:0]            hue,
	input  logic [7:0]            saturation,
	input  logic [7:0]            level,
	input  logic                  full_brightness,
	output hsv2rgb_pkg::front_t   res
);
	import hsv2rgb_pkg::*;

	logic [8:0] sat_sum;
	logic [7:0] bsat;
	logic [SECT_W-1:0] h6;
	logic [2:0] carry;
	logic [SECT_W-1:0] sector;

	assign sat_sum = {1'b0, saturation} + {1'b0, boost};
	assign bsat = (sat_sum > 9'(SCALE_IN)) ? 8'(SCALE_IN) : sat_sum[7:0];
	assign h6 = SECT_W'(hue) * SECT_W'(6);

	// (6h + 127) / 254, at most 6
	always_comb begin
		carry = '0;
		for (int j = 1; j <= 6; j++) begin
			if (h6 >= SECT_W'(SCALE_IN * j - HALF_IN))
				carry = carry + 3'd1;
		end
	end

	assign sector = h6 + SECT_W'(carry);

	assign res.sector = (sector >= SECT_W'(SECTOR_STEPS)) ? '0 : sector;
	assign res.sat = widen(bsat);
	assign res.val = full_brightness ? 8'(SCALE_OUT) : widen(level);

endmodule

// ===== design/hsv_to_rgb_light_color_core.sv =====
// HSV to 8-bit RGB converter. Each input beat (hue, saturation, level,
// full_brightness) yields one red/green/blue beat, registered through the
// six pipeline stages (input conditioning, sector split, two rounds of 8x8
// multiply followed by a rounded divide by 255, channel select). One beat is
// taken per clock while in_stall is low. Each stage holds while its successor
// is full and stalled, so bubbles are squeezed out and in_stall rises only
// when every stage holds a beat. The boost register is written through
// cfg_write/cfg_data and should change only while idle.
module hsv_to_rgb_light_color_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_write,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] hue,
	input  logic [7:0] saturation,
	input  logic [7:0] level,
	input  logic       full_brightness,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import hsv2rgb_pkg::*;

	logic [7:0] boost_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic adv1, adv2, adv3, adv4, adv5, adv6;

	front_t front;
	front_t front_s1;

	region_t region_s2;
	logic [7:0] rem_s2, sat_s2, val_s2;
	region_t region_nx;
	logic [SECT_W-1:0] base_nx;

	region_t region_s3;
	logic [7:0] val_s3;
	logic [PROD_W-1:0] prod_p_s3, prod_q_s3, prod_t_s3;

	region_t region_s4;
	logic [7:0] val_s4, p_s4, kq_s4, kt_s4;

	region_t region_s5;
	logic [7:0] val_s5, p_s5;
	logic [PROD_W-1:0] prod_q_s5, prod_t_s5;

	logic [7:0] q_nx, t_nx;
	logic [7:0] red_s6, green_s6, blue_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			boost_q <= '0;
		else if (cfg_write)
			boost_q <= cfg_data;
	end

	assign adv6 = !vld_s6 || !out_stall;
	assign adv5 = !vld_s5 || adv6;
	assign adv4 = !vld_s4 || adv5;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= in_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
			if (adv5) vld_s5 <= vld_s4;
			if (adv6) vld_s6 <= vld_s5;
		end
	end

	hsv2rgb_front u_front (
		.boost           (boost_q),
		.hue             (hue),
		.saturation      (saturation),
		.level           (level),
		.full_brightness (full_brightness),
		.res             (front)
	);

	always_ff @(posedge clk) begin
		if (adv1)
			front_s1 <= front;
	end

	// region = sector / 255
	always_comb begin
		priority if (front_s1.sector >= SECT_W'(SCALE_OUT * 5)) begin
			region_nx = RGN_MR;
			base_nx = SECT_W'(SCALE_OUT * 5);
		end else if (front_s1.sector >= SECT_W'(SCALE_OUT * 4)) begin
			region_nx = RGN_BM;
			base_nx = SECT_W'(SCALE_OUT * 4);
		end else if (front_s1.sector >= SECT_W'(SCALE_OUT * 3)) begin
			region_nx = RGN_CB;
			base_nx = SECT_W'(SCALE_OUT * 3);
		end else if (front_s1.sector >= SECT_W'(SCALE_OUT * 2)) begin
			region_nx = RGN_GC;
			base_nx = SECT_W'(SCALE_OUT * 2);
		end else if (front_s1.sector >= SECT_W'(SCALE_OUT)) begin
			region_nx = RGN_YG;
			base_nx = SECT_W'(SCALE_OUT);
		end else begin
			region_nx = RGN_RY;
			base_nx = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			region_s2 <= region_nx;
			rem_s2 <= 8'(front_s1.sector - base_nx);
			sat_s2 <= front_s1.sat;
			val_s2 <= front_s1.val;
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			region_s3 <= region_s2;
			val_s3 <= val_s2;
			prod_p_s3 <= PROD_W'(val_s2) * PROD_W'(8'(SCALE_OUT) - sat_s2)
				+ PROD_W'(HALF_IN);
			prod_q_s3 <= PROD_W'(sat_s2) * PROD_W'(rem_s2) + PROD_W'(HALF_IN);
			prod_t_s3 <= PROD_W'(sat_s2) * PROD_W'(8'(SCALE_OUT) - rem_s2)
				+ PROD_W'(HALF_IN);
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) begin
			region_s4 <= region_s3;
			val_s4 <= val_s3;
			p_s4 <= div255(prod_p_s3);
			kq_s4 <= div255(prod_q_s3);
			kt_s4 <= div255(prod_t_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv5) begin
			region_s5 <= region_s4;
			val_s5 <= val_s4;
			p_s5 <= p_s4;
			prod_q_s5 <= PROD_W'(val_s4) * PROD_W'(8'(SCALE_OUT) - kq_s4)
				+ PROD_W'(HALF_IN);
			prod_t_s5 <= PROD_W'(val_s4) * PROD_W'(8'(SCALE_OUT) - kt_s4)
				+ PROD_W'(HALF_IN);
		end
	end

	assign q_nx = div255(prod_q_s5);
	assign t_nx = div255(prod_t_s5);

	always_ff @(posedge clk) begin
		if (adv6) begin
			unique case (region_s5)
				RGN_RY: begin
					red_s6 <= val_s5; green_s6 <= t_nx; blue_s6 <= p_s5;
				end
				RGN_YG: begin
					red_s6 <= q_nx; green_s6 <= val_s5; blue_s6 <= p_s5;
				end
				RGN_GC: begin
					red_s6 <= p_s5; green_s6 <= val_s5; blue_s6 <= t_nx;
				end
				RGN_CB: begin
					red_s6 <= p_s5; green_s6 <= q_nx; blue_s6 <= val_s5;
				end
				RGN_BM: begin
					red_s6 <= t_nx; green_s6 <= p_s5; blue_s6 <= val_s5;
				end
				default: begin
					red_s6 <= val_s5; green_s6 <= p_s5; blue_s6 <= q_nx;
				end
			endcase
		end
	end

	assign out_valid = vld_s6;
	assign red = red_s6;
	assign green = green_s6;
	assign blue = blue_s6;

endmodule

// ===== design/hsv2rgb_chk.sv =====
module hsv2rgb_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue))
		else $error("output beat changed under stall");

	// input back-pressure only while a valid output beat is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while pipeline has room");

	// no beat can emerge right after reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid right after reset");

	// an idle pipe never back-pressures
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

endmodule

bind hsv_to_rgb_light_color_core hsv2rgb_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red       (red),
	.green     (green),
	.blue      (blue)
);
